// File: hdl/bsrfc_pkg.sv
`timescale 1ns / 1ps
// shared types, register indexes and bcd helpers for the frame checker
// no dependencies

package bsrfc_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_START   = 2'd0;
	localparam logic [1:0] REG_STOP    = 2'd1;
	localparam logic [1:0] REG_STATION = 2'd2;

	// reset values of the registers
	localparam logic [7:0] START_RST   = 8'd2;
	localparam logic [7:0] STOP_RST    = 8'd3;
	localparam logic [6:0] STATION_RST = 7'd1;

	// fewest body bytes that allow the full set of checks
	localparam int MIN_BODY_BYTES = 4;
	// widest body length that the result word carries
	localparam logic [6:0] LEN_SAT = 7'd127;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TOO_SHORT = 3'd1,
		ST_STATION  = 3'd2,
		ST_LENGTH   = 3'd3,
		ST_CHECKSUM = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] start_char;
		logic [7:0] stop_char;
		logic [6:0] expected_station;
	} cfg_t;

	typedef struct packed {
		status_t    frame_status;
		logic [6:0] body_length;
		logic       ack_is_zero;
	} res_t;

	// two bcd digits to binary, nibbles above nine taken as they are
	function automatic logic [7:0] bcd_value(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'b0, b[7:4]};
		bcd_value = (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
	endfunction

	// binary 0..99 to two bcd digits, tens by reciprocal multiply
	function automatic logic [7:0] bin_to_bcd(input logic [6:0] x);
		logic [15:0] prod;
		logic [3:0]  tens;
		logic [7:0]  tens10;
		logic [7:0]  ones;
		prod   = {9'b0, x} * 16'd205;
		tens   = prod[14:11];
		tens10 = ({4'b0, tens} << 3) + ({4'b0, tens} << 1);
		ones   = {1'b0, x} - tens10;
		bin_to_bcd = {tens, ones[3:0]};
	endfunction

	// sum below 300 reduced mod 100
	function automatic logic [6:0] mod100(input logic [8:0] s);
		logic [8:0] r;
		if (s >= 9'd200) begin
			r = s - 9'd200;
		end else if (s >= 9'd100) begin
			r = s - 9'd100;
		end else begin
			r = s;
		end
		mod100 = r[6:0];
	endfunction

endpackage

// File: hdl/bsrfc_in_if.sv
`timescale 1ns / 1ps
// input channel: one received serial byte per word
// no dependencies

interface bsrfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hdl/bsrfc_out_if.sv
`timescale 1ns / 1ps
// result channel: one frame verdict per word
// no dependencies

interface bsrfc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] frame_status;
	logic [6:0] body_length;
	logic       ack_is_zero;

	modport source (output valid, output frame_status, output body_length,
		output ack_is_zero, input ready);
	modport sink   (input valid, input frame_status, input body_length,
		input ack_is_zero, output ready);
endinterface

// File: hdl/bsrfc_frame_ctl.sv
`timescale 1ns / 1ps
// frame tracking state and verdict logic, one byte per cycle while step is high
// depends on bsrfc_pkg

module bsrfc_frame_ctl #(
	parameter int MAX_BODY_BYTES = 127
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	input  bsrfc_pkg::cfg_t    cfg,
	output logic               is_stop,
	output bsrfc_pkg::res_t    res
);
	import bsrfc_pkg::*;

	// counter holds MAX_BODY_BYTES + 1 as the overlong mark
	localparam int CNT_W = $clog2(MAX_BODY_BYTES + 2);
	localparam int EXT_W = 9;
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BODY_BYTES);
	localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_BODY_BYTES + 1);

	logic             in_frame_q;
	logic [CNT_W-1:0] count_q;
	logic [6:0]       sum_q;
	logic [7:0]       held_q;
	logic [7:0]       station_q;
	logic [7:0]       length_q;
	logic [7:0]       ack_q;

	logic [EXT_W-1:0] n_ext;
	logic [6:0]       sum_next;
	status_t          status;

	assign is_stop  = in_frame_q && (rx_byte == cfg.stop_char);
	assign sum_next = mod100({2'b0, sum_q} + {1'b0, bcd_value(held_q)});
	assign n_ext    = EXT_W'(count_q);

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			sum_q      <= '0;
			held_q     <= '0;
			station_q  <= '0;
			length_q   <= '0;
			ack_q      <= '0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (rx_byte == cfg.start_char) begin
					in_frame_q <= 1'b1;
					count_q    <= '0;
					sum_q      <= '0;
					held_q     <= '0;
					station_q  <= '0;
					length_q   <= '0;
					ack_q      <= '0;
				end
			end else if (rx_byte != cfg.stop_char) begin
				if (count_q >= CNT_MAX) begin
					count_q <= CNT_OVER;
				end else begin
					if (count_q != '0) begin
						sum_q <= sum_next;
					end
					held_q <= rx_byte;
					if (count_q == CNT_W'(0)) begin
						station_q <= rx_byte;
					end
					if (count_q == CNT_W'(1)) begin
						length_q <= rx_byte;
					end
					if (count_q == CNT_W'(2)) begin
						ack_q <= rx_byte;
					end
					count_q <= count_q + CNT_W'(1);
				end
			end else begin
				in_frame_q <= 1'b0;
			end
		end
	end

	// verdict, checks in priority order
	always_comb begin
		priority if (n_ext < EXT_W'(MIN_BODY_BYTES)) begin
			status = ST_TOO_SHORT;
		end else if (bcd_value(station_q) != {1'b0, cfg.expected_station}) begin
			status = ST_STATION;
		end else if ((n_ext > EXT_W'(MAX_BODY_BYTES)) ||
			({1'b0, bcd_value(length_q)} != n_ext)) begin
			status = ST_LENGTH;
		end else if (held_q != bin_to_bcd(sum_q)) begin
			status = ST_CHECKSUM;
		end else begin
			status = ST_OK;
		end
	end

	assign res.frame_status = status;
	assign res.body_length  = (n_ext > EXT_W'(LEN_SAT)) ? LEN_SAT : n_ext[6:0];
	assign res.ack_is_zero  = (n_ext >= EXT_W'(3)) && (ack_q == 8'h00);

endmodule

// File: hdl/bsrfc_out_reg.sv
`timescale 1ns / 1ps
// result register that holds a verdict word until the receiver takes it
// depends on bsrfc_pkg and bsrfc_out_if

module bsrfc_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  bsrfc_pkg::res_t res,
	output logic            space,
	bsrfc_out_if.source     res_out
);
	import bsrfc_pkg::*;

	logic valid_q;
	res_t res_q;

	assign space = !valid_q || res_out.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign res_out.valid        = valid_q;
	assign res_out.frame_status = res_q.frame_status;
	assign res_out.body_length  = res_q.body_length;
	assign res_out.ack_is_zero  = res_q.ack_is_zero;

endmodule

// File: hdl/bcd_sum_response_frame_checker.sv
`timescale 1ns / 1ps
// top level of the bcd sum response frame checker
// depends on bsrfc_pkg, bsrfc_in_if, bsrfc_out_if, bsrfc_frame_ctl, bsrfc_out_reg
//
// Usage:
// rx carries received serial bytes, one per word. The checker hunts for the
// start character, collects body bytes up to the stop character, and sends
// one verdict word on res for each closed frame: status, body length
// (saturated at 127) and whether the third body byte is zero.
// Throughput is one byte per cycle, unless a stop byte waits for the result
// register. A byte is taken into the input register at the accept edge; the
// verdict of a stop byte passes combinationally from the input register to
// the result register, and res shows it from the result register.
// When res stalls, bytes that close no frame keep flowing; a stop byte waits
// in the input register until the result register is free, and rx.ready
// drops only then.
// The APB port holds start_char (0x0), stop_char (0x4) and
// expected_station (0x8); write them only while the checker is idle.
// Asynchronous reset restores the register defaults (2, 3, 1), empties both
// registers and returns to hunting. No clearing pass is needed.

module bcd_sum_response_frame_checker #(
	parameter int MAX_BODY_BYTES = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	bsrfc_in_if.sink    rx,
	bsrfc_out_if.source res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bsrfc_pkg::*;

	cfg_t       cfg_q;
	logic       rx_valid_s1;
	logic [7:0] rx_byte_s1;
	logic       is_stop;
	logic       space;
	logic       advance;
	logic       load;
	res_t       verdict;
	logic [1:0] reg_idx;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_char       <= START_RST;
			cfg_q.stop_char        <= STOP_RST;
			cfg_q.expected_station <= STATION_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_START:   cfg_q.start_char       <= pwdata[7:0];
				REG_STOP:    cfg_q.stop_char        <= pwdata[7:0];
				REG_STATION: cfg_q.expected_station <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			REG_START:   prdata = {24'b0, cfg_q.start_char};
			REG_STOP:    prdata = {24'b0, cfg_q.stop_char};
			REG_STATION: prdata = {25'b0, cfg_q.expected_station};
			default:     prdata = '0;
		endcase
	end

	// input register, a stop byte holds while the result register is full
	assign advance  = rx_valid_s1 && (!is_stop || space);
	assign load     = advance && is_stop;
	assign rx.ready = !rx_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			rx_valid_s1 <= 1'b1;
		end else if (advance) begin
			rx_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	bsrfc_frame_ctl #(
		.MAX_BODY_BYTES(MAX_BODY_BYTES)
	) u_frame_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (rx_byte_s1),
		.cfg     (cfg_q),
		.is_stop (is_stop),
		.res     (verdict)
	);

	bsrfc_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.res     (verdict),
		.space   (space),
		.res_out (res)
	);

	// a held byte that cannot move stays put
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid_s1 && !advance |=> rx_valid_s1 && $stable(rx_byte_s1))
		else $error("input register lost a byte while stalled");

	// no verdict overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !load)
		else $error("verdict overwritten before it was taken");

	// short frames always report too short
	a_short_status: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.body_length < 7'd4) |-> res.frame_status == ST_TOO_SHORT)
		else $error("short frame with wrong status");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// testbench for the bcd sum response frame checker: drives serial bytes and apb
// writes, predicts each frame verdict and checks every result word in order
// depends on bsrfc_pkg, bsrfc_in_if, bsrfc_out_if and bcd_sum_response_frame_checker

module tb_top;
	import bsrfc_pkg::*;

	localparam int MAX_BODY    = 127;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 4;
	localparam int MAX_PRINTS  = 100;
	// index past the last register, writes there must change nothing
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef enum int {
		FR_GOOD,
		FR_BAD_STATION,
		FR_BAD_LENGTH,
		FR_BAD_SUM,
		FR_SHORT
	} frame_kind_e;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	bsrfc_in_if  rx();
	bsrfc_out_if res();

	bcd_sum_response_frame_checker #(
		.MAX_BODY_BYTES(MAX_BODY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers and frame state
	logic [7:0] cfg_start;
	logic [7:0] cfg_stop;
	logic [6:0] cfg_station;
	logic       frame_open;
	int         body_cnt;
	int         sum_dec;
	logic [7:0] last_body;
	logic [7:0] stn_byte;
	logic [7:0] len_byte;
	logic [7:0] ack_byte;

	res_t verdicts_due[$];

	int err_count   = 0;
	int cycle_count = 0;
	int busy_bytes  = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int   hold_left = 0;

	task automatic report_error(input string msg);
		if (err_count < MAX_PRINTS) begin
			$display("%0t ERROR %s", $time, msg);
		end
		err_count++;
	endtask

	// two bcd digits as a decimal number, nibbles above nine kept
	function automatic int dec_of(input logic [7:0] b);
		return b[7:4] * 10 + b[3:0];
	endfunction

	// decimal 0..159 as a tens nibble and a units nibble
	function automatic logic [7:0] as_digits(input int x);
		logic [3:0] t;
		logic [3:0] u;
		t = 4'(x / 10);
		u = 4'(x % 10);
		return {t, u};
	endfunction

	task automatic clear_frame_state();
		body_cnt  = 0;
		sum_dec   = 0;
		last_body = 8'h00;
		stn_byte  = 8'h00;
		len_byte  = 8'h00;
		ack_byte  = 8'h00;
	endtask

	// works out the verdict, if any, that one accepted byte causes
	task automatic predict_rx_byte(input logic [7:0] b);
		res_t       v;
		status_t    st;
		int         n;
		logic [7:0] sum_digits;
		if (!frame_open) begin
			if (b == cfg_start) begin
				frame_open = 1'b1;
				clear_frame_state();
			end
		end else if (b != cfg_stop) begin
			if (body_cnt >= MAX_BODY) begin
				body_cnt = MAX_BODY + 1;
			end else begin
				if (body_cnt > 0) begin
					sum_dec = (sum_dec + dec_of(last_body)) % 100;
				end
				last_body = b;
				case (body_cnt)
					0: stn_byte = b;
					1: len_byte = b;
					2: ack_byte = b;
					default: ;
				endcase
				body_cnt++;
			end
		end else begin
			frame_open = 1'b0;
			n = body_cnt;
			sum_digits = as_digits(sum_dec);
			if (n < MIN_BODY_BYTES) begin
				st = ST_TOO_SHORT;
			end else if (dec_of(stn_byte) != cfg_station) begin
				st = ST_STATION;
			end else if (n > MAX_BODY || dec_of(len_byte) != n) begin
				st = ST_LENGTH;
			end else if (last_body != sum_digits) begin
				st = ST_CHECKSUM;
			end else begin
				st = ST_OK;
			end
			v.frame_status = st;
			v.body_length  = (n > 127) ? LEN_SAT : n[6:0];
			v.ack_is_zero  = (n >= 3 && ack_byte == 8'h00);
			verdicts_due = {verdicts_due, v};
		end
	endtask

	// offer one byte after a random gap and wait for it to be taken
	task automatic send_word(input logic [7:0] b);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < snd_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (!rx.ready);
		if (frame_open || b == cfg_start) begin
			busy_bytes++;
		end
		predict_rx_byte(b);
	endtask

	// stop offering and wait until every verdict has come back
	task automatic wait_verdicts_drained();
		rx.valid <= 1'b0;
		do @(posedge clk); while (verdicts_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_START:   cfg_start   = val[7:0];
			REG_STOP:    cfg_stop    = val[7:0];
			REG_STATION: cfg_station = val[6:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic cfg_read(input logic [1:0] idx, output logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		val = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write all three registers with junk above the field, then read them back
	task automatic load_settings(input logic [7:0] s, input logic [7:0] t,
		input logic [6:0] st);
		logic [31:0] rd;
		wait_verdicts_drained();
		cfg_write(REG_START, {16'($urandom_range(0, 65535)), 8'h00, s} & 32'hffff00ff);
		cfg_write(REG_STOP, {16'($urandom_range(0, 65535)), 8'h00, t} & 32'hffff00ff);
		cfg_write(REG_STATION,
			{16'($urandom_range(0, 65535)), 8'h00, 1'b0, st} & 32'hffff007f);
		cfg_read(REG_START, rd);
		if (rd[7:0] !== cfg_start) begin
			report_error($sformatf("start_char read %h want %h", rd[7:0], cfg_start));
		end
		cfg_read(REG_STOP, rd);
		if (rd[7:0] !== cfg_stop) begin
			report_error($sformatf("stop_char read %h want %h", rd[7:0], cfg_stop));
		end
		cfg_read(REG_STATION, rd);
		if (rd[6:0] !== cfg_station) begin
			report_error($sformatf("station read %h want %h", rd[6:0], cfg_station));
		end
	endtask

	// random body byte that cannot close the frame, zero fairly often
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do begin
			b = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
		end while (b == cfg_stop);
		return b;
	endfunction

	function automatic int pick_body_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(MIN_BODY_BYTES, 12);
		end else if (r < 94) begin
			return $urandom_range(13, 40);
		end else if (r < 98) begin
			return $urandom_range(100, MAX_BODY);
		end
		return $urandom_range(MAX_BODY + 1, MAX_BODY + 7);
	endfunction

	// one frame from start to stop, well formed unless the kind says otherwise
	task automatic send_frame(input frame_kind_e kind, input int n);
		logic [7:0] body[$];
		int acc;
		body.delete();
		if (kind == FR_SHORT) begin
			for (int i = 0; i < n; i++) begin
				body = {body, body_byte()};
			end
		end else begin
			body = {body, as_digits(cfg_station)};
			body = {body, as_digits(n)};
			for (int i = 2; i < n - 1; i++) begin
				body = {body, body_byte()};
			end
			acc = 0;
			foreach (body[i]) begin
				acc += dec_of(body[i]);
			end
			body = {body, as_digits(acc % 100)};
			case (kind)
				FR_BAD_STATION: begin
					if ($urandom_range(0, 1)) begin
						body[0] = as_digits((cfg_station + $urandom_range(1, 99)) % 100);
					end else begin
						body[0] = body_byte();
					end
				end
				FR_BAD_LENGTH: body[1] = as_digits((n + $urandom_range(1, 9)) % 150);
				FR_BAD_SUM:    body[n - 1] = body[n - 1] ^ (8'h01 << $urandom_range(0, 7));
				default: ;
			endcase
		end
		send_word(cfg_start);
		foreach (body[i]) begin
			send_word(body[i]);
		end
		send_word(cfg_stop);
	endtask

	// one random frame, its kind weighted towards well formed
	task automatic send_random_frame();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4) begin
			send_frame(FR_GOOD, pick_body_len());
		end else if (k == 4) begin
			send_frame(FR_BAD_STATION, pick_body_len());
		end else if (k == 5) begin
			send_frame(FR_BAD_LENGTH, pick_body_len());
		end else if (k == 6) begin
			send_frame(FR_BAD_SUM, pick_body_len());
		end else begin
			send_frame(FR_SHORT, $urandom_range(0, 3));
		end
	endtask

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	// compare each accepted verdict word with the oldest expected one
	always @(posedge clk) begin : check_verdict
		res_t want;
		if (arst_n && res.valid && res.ready) begin
			if (verdicts_due.size() == 0) begin
				report_error($sformatf("verdict with none expected: status %0d len %0d",
					res.frame_status, res.body_length));
			end else begin
				want = verdicts_due.pop_front();
				if (res.frame_status !== want.frame_status) begin
					report_error($sformatf("frame_status %0d want %0d",
						res.frame_status, want.frame_status));
				end
				if (res.body_length !== want.body_length) begin
					report_error($sformatf("body_length %0d want %0d",
						res.body_length, want.body_length));
				end
				if (res.ack_is_zero !== want.ack_is_zero) begin
					report_error($sformatf("ack_is_zero %0b want %0b",
						res.ack_is_zero, want.ack_is_zero));
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// hunting noise, empty and short frames, a good frame, start inside a frame
	task automatic test_directed();
		logic [7:0] seq[$];
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		seq = '{8'h00, 8'hff, 8'h03,
			8'h02, 8'h03,
			8'h02, 8'h01, 8'h55, 8'h00, 8'h03,
			8'h02, 8'h01, 8'h04, 8'h00, 8'h05, 8'h03,
			8'h02, 8'h01, 8'h05, 8'h02, 8'h99, 8'h07, 8'h03};
		foreach (seq[i]) begin
			send_word(seq[i]);
		end
	endtask

	// unused index, then extremes: start_char and expected_station low, stop_char high
	task automatic test_register_access();
		logic [31:0] rd;
		wait_verdicts_drained();
		cfg_write(REG_NONE, $urandom);
		cfg_read(REG_START, rd);
		if (rd[7:0] !== cfg_start) begin
			report_error($sformatf("start_char read %h want %h after unused write",
				rd[7:0], cfg_start));
		end
		load_settings(8'h00, 8'hff, 7'd0);
	endtask

	// mostly frames with random content, the rest noise and broken frames
	task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n);
		int target;
		int r;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		target = busy_bytes + n;
		while (busy_bytes < target) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_random_frame();
			end else if (r < 85) begin
				repeat ($urandom_range(1, 5)) send_word(8'($urandom));
			end else if (r < 93) begin
				// opened and never closed, the next start lands in the body
				send_word(cfg_start);
				repeat ($urandom_range(0, 5)) send_word(body_byte());
			end else begin
				send_word($urandom_range(0, 1) ? cfg_stop : cfg_start);
			end
		end
	endtask

	// receiver holds off while short frames keep coming, so the input stalls
	task automatic test_backpressure();
		load_settings(START_RST, STOP_RST, STATION_RST);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_req <= ~hold_req;
		repeat (40) send_frame(FR_SHORT, $urandom_range(0, 3));
	endtask

	// sender pauses mid-run until every verdict is back
	task automatic test_pause_until_drained();
		snd_idle_pct = 10;
		rcv_idle_pct = 10;
		repeat (5) send_random_frame();
		wait_verdicts_drained();
		repeat (5) send_random_frame();
	endtask

	initial begin
		arst_n     = 1'b0;
		rx.valid   = 1'b0;
		rx.rx_byte = 8'h00;
		res.ready  = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = 4'h0;
		pwdata     = 32'h0;
		cfg_start   = START_RST;
		cfg_stop    = STOP_RST;
		cfg_station = STATION_RST;
		frame_open  = 1'b0;
		clear_frame_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_register_access();
		test_random_traffic(24, 83, 600);
		load_settings(8'hff, 8'h00, 7'd99);
		test_random_traffic(83, 24, 600);
		// start and stop the same character
		load_settings(8'h7e, 8'h7e, 7'($urandom_range(0, 99)));
		test_random_traffic(0, 0, 250);
		load_settings(8'($urandom), 8'($urandom), 7'($urandom_range(0, 99)));
		test_random_traffic(0, 0, 250);
		test_backpressure();
		test_pause_until_drained();

		wait_verdicts_drained();
		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/bsrfc_pkg.sv
hdl/bsrfc_in_if.sv
hdl/bsrfc_out_if.sv
hdl/bsrfc_frame_ctl.sv
hdl/bsrfc_out_reg.sv
hdl/bcd_sum_response_frame_checker.sv
dv/tb_top.sv
